>>> sv/triangle_tangent_basis_assert.svh
// ----------------------------------------------------------------------------
// triangle_tangent_basis assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BASIS_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_ASSERT_SVH

// same-cycle implication
`define TTB_ASSERT_IMP(lbl, clk, rst_n, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("tangent basis: same-cycle check failed");

// next-cycle implication
`define TTB_ASSERT_NXT(lbl, clk, rst_n, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("tangent basis: next-cycle check failed");

`endif

>>> sv/tbn_pkg.sv
// ----------------------------------------------------------------------------
// tbn_pkg
// Widths, latencies and helpers of the triangle tangent basis pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tbn_pkg;

  localparam int FIELD_W    = 16;
  localparam int VEC_W      = 3 * FIELD_W;
  localparam int UV_W       = 2 * FIELD_W;
  localparam int IDX_FIELD_W = 16;
  localparam int S_DATA_W   = 3 * VEC_W + 3 * UV_W + 3 * IDX_FIELD_W;
  localparam int M_DATA_W   = 2 * VEC_W + 3 * IDX_FIELD_W;

  localparam int EDGE_W     = FIELD_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int RAW_W      = PROD_W + 2;
  localparam int MAG_W      = RAW_W;
  localparam int SH_W       = 30;
  localparam int SHIFT_W    = 3;
  localparam int SQ_W       = 2 * SH_W;
  localparam int Q_W        = SQ_W + 2;
  localparam int ACC_W      = 64;
  localparam int SQRT_STEPS = 32;
  localparam int ROOT_W     = 31;
  localparam int DEN_W      = ROOT_W + 1;
  localparam int FRAC_OUT   = 14;
  localparam int QUO_W      = FRAC_OUT + 1;
  localparam int DIV_W      = 48;

  localparam int FRONT_LAT  = 4;
  localparam int NORM_LAT   = 4 + SQRT_STEPS + 1 + QUO_W + 1;

  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PROD_W:0]   diff_t;
  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic [2:0][SH_W-1:0]     mag3_t;

  function automatic edge_t diff16(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] a);
    return {b[FIELD_W-1], b} - {a[FIELD_W-1], a};
  endfunction

endpackage

`default_nettype wire

>>> sv/tbn_front.sv
// ----------------------------------------------------------------------------
// tbn_front
// Edges, UV cross term and signed raw tangent and bitangent, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tbn_pkg::VEC_W-1:0]   pos_a_i,
  input  logic [tbn_pkg::VEC_W-1:0]   pos_b_i,
  input  logic [tbn_pkg::VEC_W-1:0]   pos_c_i,
  input  logic [tbn_pkg::UV_W-1:0]    uv_a_i,
  input  logic [tbn_pkg::UV_W-1:0]    uv_b_i,
  input  logic [tbn_pkg::UV_W-1:0]    uv_c_i,
  output logic                        valid_o,
  output tbn_pkg::raw_t               t_o [3],
  output tbn_pkg::raw_t               b_o [3]
);

  localparam int FW = tbn_pkg::FIELD_W;
  localparam int PW = tbn_pkg::PROD_W;

  tbn_pkg::edge_t e1_d [3], e2_d [3], e1_q [3], e2_q [3];
  tbn_pkg::edge_t d1u_d, d1v_d, d2u_d, d2v_d, d1u_q, d1v_q, d2u_q, d2v_q;
  tbn_pkg::prod_t cpa_q, cpb_q, ta_q [3], tb_q [3], ba_q [3], bb_q [3];
  tbn_pkg::diff_t cp_d, tr_d [3], br_d [3], tr_q [3], br_q [3];
  tbn_pkg::raw_t  t_d [3], b_d [3], t_q [3], b_q [3];
  logic           neg_d, neg_q;
  logic           v1_q, v2_q, v3_q, v4_q;
  logic           keep_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = tbn_pkg::diff16(pos_b_i[FW*k +: FW], pos_a_i[FW*k +: FW]);
      e2_d[k] = tbn_pkg::diff16(pos_c_i[FW*k +: FW], pos_a_i[FW*k +: FW]);
    end
    d1u_d = tbn_pkg::diff16(uv_b_i[FW-1:0], uv_a_i[FW-1:0]);
    d1v_d = tbn_pkg::diff16(uv_b_i[2*FW-1:FW], uv_a_i[2*FW-1:FW]);
    d2u_d = tbn_pkg::diff16(uv_c_i[FW-1:0], uv_a_i[FW-1:0]);
    d2v_d = tbn_pkg::diff16(uv_c_i[2*FW-1:FW], uv_a_i[2*FW-1:FW]);
  end

  always_comb begin
    cp_d   = {cpa_q[PW-1], cpa_q} - {cpb_q[PW-1], cpb_q};
    neg_d  = cp_d[PW];
    keep_d = v2_q && (cp_d != '0);
    for (int k = 0; k < 3; k++) begin
      tr_d[k] = {ta_q[k][PW-1], ta_q[k]} - {tb_q[k][PW-1], tb_q[k]};
      br_d[k] = {ba_q[k][PW-1], ba_q[k]} - {bb_q[k][PW-1], bb_q[k]};
      t_d[k]  = neg_q ? -{tr_q[k][PW], tr_q[k]} : {tr_q[k][PW], tr_q[k]};
      b_d[k]  = neg_q ? -{br_q[k][PW], br_q[k]} : {br_q[k][PW], br_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= keep_d;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1u_q <= d1u_d;
      d1v_q <= d1v_d;
      d2u_q <= d2u_d;
      d2v_q <= d2v_d;
      cpa_q <= d1u_q * d2v_q;
      cpb_q <= d1v_q * d2u_q;
      neg_q <= neg_d;
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= e1_d[k];
        e2_q[k] <= e2_d[k];
        ta_q[k] <= d2v_q * e1_q[k];
        tb_q[k] <= d1v_q * e2_q[k];
        ba_q[k] <= d1u_q * e2_q[k];
        bb_q[k] <= d2u_q * e1_q[k];
        tr_q[k] <= tr_d[k];
        br_q[k] <= br_d[k];
        t_q[k]  <= t_d[k];
        b_q[k]  <= b_d[k];
      end
    end
  end

  assign valid_o = v4_q;
  assign t_o     = t_q;
  assign b_o     = b_q;

endmodule

`default_nettype wire

>>> sv/tbn_norm.sv
// ----------------------------------------------------------------------------
// tbn_norm
// Unit vector in Q1.14: preshift, squares, pipelined square root and
// pipelined restoring division, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_norm (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  tbn_pkg::raw_t             vec_i [3],
  output logic [tbn_pkg::VEC_W-1:0] packed_o
);

  localparam int MW = tbn_pkg::MAG_W;
  localparam int SW = tbn_pkg::SH_W;
  localparam int AW = tbn_pkg::ACC_W;
  localparam int NS = tbn_pkg::SQRT_STEPS;
  localparam int QW = tbn_pkg::QUO_W;
  localparam int DW = tbn_pkg::DIV_W;
  localparam int FW = tbn_pkg::FIELD_W;

  logic [2:0]                     neg1_q, neg2_q, neg3_q, neg4_q;
  logic [2:0][MW-1:0]             mag1_q;
  logic [MW-1:0]                  m_d;
  logic [tbn_pkg::SHIFT_W-1:0]    s_d;
  tbn_pkg::mag3_t                 mag2_d, mag2_q, mag3_q, mag4_q;
  logic [2:0][tbn_pkg::SQ_W-1:0]  sq3_q;
  logic [tbn_pkg::Q_W-1:0]        q4_q;

  logic [AW-1:0]                  xin [NS], rin [NS], trial [NS], bitv [NS];
  logic [AW-1:0]                  nx_d [NS], nr_d [NS], sx_q [NS], sr_q [NS];
  tbn_pkg::mag3_t                 smag_q [NS];
  logic [2:0]                     sneg_q [NS];

  logic [tbn_pkg::ROOT_W-1:0]     root;
  logic [2:0][DW-1:0]             num_d;
  logic [2:0][DW-1:0]             drem_q [QW+1], nrem_d [QW];
  logic [2:0][QW-1:0]             dquo_q [QW+1], nquo_d [QW];
  logic [tbn_pkg::DEN_W-1:0]      dden_q [QW+1];
  logic [DW-1:0]                  dsh [QW];
  logic                           dzero_q [QW+1];
  logic [2:0]                     dneg_q [QW+1];
  logic [tbn_pkg::VEC_W-1:0]      pack_d, pack_q;

  always_comb begin
    m_d = mag1_q[0];
    for (int k = 1; k < 3; k++) begin
      if (mag1_q[k] > m_d) m_d = mag1_q[k];
    end
    s_d = '0;
    for (int j = 0; j < MW - SW; j++) begin
      if (m_d[SW+j]) s_d = tbn_pkg::SHIFT_W'(j + 1);
    end
    for (int k = 0; k < 3; k++) begin
      mag2_d[k] = SW'(mag1_q[k] >> s_d);
    end
  end

  always_comb begin
    xin[0] = AW'(q4_q);
    rin[0] = '0;
    for (int i = 1; i < NS; i++) begin
      xin[i] = sx_q[i-1];
      rin[i] = sr_q[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      bitv[i]  = AW'(1) << (2 * (NS - 1 - i));
      trial[i] = rin[i] + bitv[i];
      if (xin[i] >= trial[i]) begin
        nx_d[i] = xin[i] - trial[i];
        nr_d[i] = (rin[i] >> 1) + bitv[i];
      end else begin
        nx_d[i] = xin[i];
        nr_d[i] = rin[i] >> 1;
      end
    end
  end

  assign root = tbn_pkg::ROOT_W'(sr_q[NS-1]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = DW'({smag_q[NS-1][k], {QW{1'b0}}}) + DW'(root);
    end
    for (int j = 0; j < QW; j++) begin
      dsh[j] = DW'(dden_q[j]) << (QW - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if (drem_q[j][k] >= dsh[j]) begin
          nrem_d[j][k] = drem_q[j][k] - dsh[j];
          nquo_d[j][k] = dquo_q[j][k] | (QW'(1) << (QW - 1 - j));
        end else begin
          nrem_d[j][k] = drem_q[j][k];
          nquo_d[j][k] = dquo_q[j][k];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (dzero_q[QW]) begin
        pack_d[FW*k +: FW] = '0;
      end else if (dneg_q[QW][k]) begin
        pack_d[FW*k +: FW] = -FW'(dquo_q[QW][k]);
      end else begin
        pack_d[FW*k +: FW] = FW'(dquo_q[QW][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg1_q[k] <= vec_i[k][MW-1];
        mag1_q[k] <= vec_i[k][MW-1] ? MW'(-vec_i[k]) : MW'(vec_i[k]);
        sq3_q[k]  <= mag2_q[k] * mag2_q[k];
      end
      mag2_q <= mag2_d;
      neg2_q <= neg1_q;
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      q4_q   <= tbn_pkg::Q_W'(sq3_q[0]) + tbn_pkg::Q_W'(sq3_q[1])
              + tbn_pkg::Q_W'(sq3_q[2]);
      mag4_q <= mag3_q;
      neg4_q <= neg3_q;
      for (int i = 0; i < NS; i++) begin
        sx_q[i] <= nx_d[i];
        sr_q[i] <= nr_d[i];
      end
      smag_q[0] <= mag4_q;
      sneg_q[0] <= neg4_q;
      for (int i = 1; i < NS; i++) begin
        smag_q[i] <= smag_q[i-1];
        sneg_q[i] <= sneg_q[i-1];
      end
      drem_q[0]  <= num_d;
      dquo_q[0]  <= '0;
      dden_q[0]  <= {root, 1'b0};
      dzero_q[0] <= (root == '0);
      dneg_q[0]  <= sneg_q[NS-1];
      for (int j = 0; j < QW; j++) begin
        drem_q[j+1]  <= nrem_d[j];
        dquo_q[j+1]  <= nquo_d[j];
        dden_q[j+1]  <= dden_q[j];
        dzero_q[j+1] <= dzero_q[j];
        dneg_q[j+1]  <= dneg_q[j];
      end
      pack_q <= pack_d;
    end
  end

  assign packed_o = pack_q;

endmodule

`default_nettype wire

>>> sv/triangle_tangent_basis.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Per-triangle unit tangent and bitangent from positions and UVs.
// ----------------------------------------------------------------------------
// channel   dir  fields (lowest bit first)
// s_axis    in   pos_a pos_b pos_c uv_a uv_b uv_c index_a index_b index_c
// m_axis    out  tangent_out bitangent_out out_index_a out_index_b out_index_c
//
// One triangle per cycle unless the output stalls; 4 front stages and 53
// normalize stages, set by the 32-step square root and the 15-step divider.
// Triangles with a zero UV cross term produce no output beat.
// Reset clears only the valid bits.
// The whole pipeline stalls while the output beat waits; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_basis #(
  parameter int INDEX_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // pos_a, pos_b, pos_c, uv_a, uv_b, uv_c, index_a, index_b, index_c
  input  logic [tbn_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tangent_out, bitangent_out, out_index_a, out_index_b, out_index_c
  output logic [tbn_pkg::M_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int VW    = tbn_pkg::VEC_W;
  localparam int UW    = tbn_pkg::UV_W;
  localparam int XW    = tbn_pkg::IDX_FIELD_W;
  localparam int IDX_W = (INDEX_BITS < XW) ? INDEX_BITS : XW;
  localparam int LAT   = tbn_pkg::FRONT_LAT + tbn_pkg::NORM_LAT;
  localparam int NL    = tbn_pkg::NORM_LAT;
  localparam int IO    = 3 * VW + 3 * UW;

  logic              en;
  logic              fv;
  tbn_pkg::raw_t     t_raw [3], b_raw [3];
  logic [VW-1:0]     tan, bit_tan;
  logic              vn_q [NL];
  logic [2:0][IDX_W-1:0] idx_q [LAT];

  assign en              = !vn_q[NL-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  tbn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .pos_a_i (s_axis_tdata_i[VW-1:0]),
    .pos_b_i (s_axis_tdata_i[2*VW-1:VW]),
    .pos_c_i (s_axis_tdata_i[3*VW-1:2*VW]),
    .uv_a_i  (s_axis_tdata_i[3*VW+UW-1:3*VW]),
    .uv_b_i  (s_axis_tdata_i[3*VW+2*UW-1:3*VW+UW]),
    .uv_c_i  (s_axis_tdata_i[3*VW+3*UW-1:3*VW+2*UW]),
    .valid_o (fv),
    .t_o     (t_raw),
    .b_o     (b_raw)
  );

  tbn_norm u_norm_t (
    .clk_i    (clk_i),
    .en_i     (en),
    .vec_i    (t_raw),
    .packed_o (tan)
  );

  tbn_norm u_norm_b (
    .clk_i    (clk_i),
    .en_i     (en),
    .vec_i    (b_raw),
    .packed_o (bit_tan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NL; i++) vn_q[i] <= 1'b0;
    end else if (en) begin
      vn_q[0] <= fv;
      for (int i = 1; i < NL; i++) vn_q[i] <= vn_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        idx_q[0][k] <= IDX_W'(s_axis_tdata_i[IO + XW*k +: XW]);
      end
      for (int i = 1; i < LAT; i++) idx_q[i] <= idx_q[i-1];
    end
  end

  assign m_axis_tvalid_o = vn_q[NL-1];
  assign m_axis_tdata_o  = {XW'(idx_q[LAT-1][2]), XW'(idx_q[LAT-1][1]),
                            XW'(idx_q[LAT-1][0]), bit_tan, tan};

endmodule

`default_nettype wire

>>> sv/tbn_checker.sv
// ----------------------------------------------------------------------------
// tbn_checker
// Port-level checks of the tangent basis block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_tangent_basis_assert.svh"

module tbn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tready_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [tbn_pkg::M_DATA_W-1:0]  m_tdata_i
);

  localparam int FW = tbn_pkg::FIELD_W;

  logic [FW-1:0] comp [6];
  logic          unit_ok;

  always_comb begin
    unit_ok = 1'b1;
    for (int k = 0; k < 6; k++) begin
      comp[k] = m_tdata_i[FW*k +: FW];
      if (comp[k][FW-1]) begin
        if (!comp[k][FW-2]) unit_ok = 1'b0;
      end else if (comp[k][FW-2] && (comp[k][FW-3:0] != '0)) begin
        unit_ok = 1'b0;
      end
    end
  end

  `TTB_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i)
  `TTB_ASSERT_NXT(a_data_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, $stable(m_tdata_i))
  `TTB_ASSERT_IMP(a_ready_flow, clk_i, rst_ni, m_tready_i, s_tready_i)
  `TTB_ASSERT_IMP(a_unit_range, clk_i, rst_ni, m_tvalid_i, unit_ok)

endmodule

bind triangle_tangent_basis tbn_checker u_tbn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire
